// ----- rtl/core/chandy_misra_fork_arbiter_macros.svh -----
// assertion macros for the fork arbiter
// they expect clk and rst_n in scope
`ifndef CHANDY_MISRA_FORK_ARBITER_MACROS_SVH
`define CHANDY_MISRA_FORK_ARBITER_MACROS_SVH

`ifndef SYNTH
`define CMFA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cmfa assertion failed");
`define CMFA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("cmfa assertion failed");
`else
`define CMFA_ASSERT(lbl, prop)
`define CMFA_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ----- rtl/core/cmfa_pkg.sv -----
`timescale 1ns / 1ps
package cmfa_pkg;

  localparam int NUM_USERS = 16;
  localparam int IDX_W     = $clog2(NUM_USERS);

  localparam logic [1:0] OP_REQ = 2'd0;
  localparam logic [1:0] OP_EAT = 2'd1;
  localparam logic [1:0] OP_REL = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    idx_t owner;
    logic dirty;
    logic pending;
    idx_t requester;
  } fork_ent_t;

  typedef struct packed {
    logic       en;
    logic [1:0] op;
    idx_t       user;
  } step_ctl_t;

  typedef struct packed {
    fork_ent_t ent;
    logic      move;
    logic      own;
  } fork_upd_t;

  function automatic logic idx_ok(input idx_t i);
    return (IDX_W + 1)'(i) < (IDX_W + 1)'(NUM_USERS);
  endfunction

endpackage

// ----- rtl/core/cmfa_fork_unit.sv -----
`timescale 1ns / 1ps
// one fork entry per call: request, dirty marking and handover attempt
module cmfa_fork_unit (
  input  cmfa_pkg::step_ctl_t ctl,
  input  cmfa_pkg::fork_ent_t ent,
  input  logic                holder_eating,
  output cmfa_pkg::fork_upd_t upd
);

  logic own;
  logic try_ok;

  assign own = (ent.owner == ctl.user);
  assign try_ok = cmfa_pkg::idx_ok(ent.owner) && cmfa_pkg::idx_ok(ent.requester);

  always_comb begin
    upd.ent  = ent;
    upd.move = 1'b0;
    upd.own  = own;
    if (ctl.en) begin
      case (ctl.op)
        cmfa_pkg::OP_REQ: begin
          if (!own) begin
            upd.ent.pending   = 1'b1;
            upd.ent.requester = ctl.user;
            // asker differs from holder here
            if (ent.dirty && !holder_eating && cmfa_pkg::idx_ok(ctl.user)) begin
              upd.ent.owner   = ctl.user;
              upd.ent.dirty   = 1'b0;
              upd.ent.pending = 1'b0;
              upd.move        = 1'b1;
            end
          end
        end
        cmfa_pkg::OP_REL: begin
          if (own) begin
            upd.ent.dirty = 1'b1;
          end
          if (ent.pending && (ent.requester != ent.owner) && try_ok
              && (ent.dirty || own) && !holder_eating) begin
            upd.ent.owner   = ent.requester;
            upd.ent.dirty   = 1'b0;
            upd.ent.pending = 1'b0;
            upd.move        = 1'b1;
          end
        end
        default: begin
          upd.move = 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/chandy_misra_fork_arbiter.sv -----
`timescale 1ns / 1ps
// out_tvalid comes from the result register, loaded from step two on once the output is free
// events are taken one at a time; the shared fork unit handles one fork entry
//   per cycle, two steps per event
// in_tready is high whenever idle; a result not yet taken holds the next event after step two
// reset: fork k owned by user k and dirty, no requests pending, nobody eating
module chandy_misra_fork_arbiter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // op[1:0], user[5:2], fork_wanted[9:6],
                                  // left_fork[13:10], right_fork[17:14], zeros
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // granted[0], forks_moved[2:1], zeros
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_A    = 2'd1;
  localparam logic [1:0] ST_B    = 2'd2;
  localparam logic [1:0] ST_WAIT = 2'd3;

  logic [1:0] state_r, state_nxt;

  cmfa_pkg::idx_t fork_owner_r [cmfa_pkg::NUM_USERS];
  cmfa_pkg::idx_t fork_requester_r [cmfa_pkg::NUM_USERS];
  logic [cmfa_pkg::NUM_USERS-1:0] fork_dirty_r;
  logic [cmfa_pkg::NUM_USERS-1:0] request_pending_r;
  logic [cmfa_pkg::NUM_USERS-1:0] user_eating_r;

  logic [1:0]     op_r;
  cmfa_pkg::idx_t user_r;
  cmfa_pkg::idx_t fork_a_r;
  cmfa_pkg::idx_t fork_b_r;
  logic           act_r;
  logic           own_a_r;
  logic           granted_r;
  logic [1:0]     moved_r;
  logic           out_valid_r;
  logic [7:0]     out_data_r;

  logic [1:0]     in_op;
  cmfa_pkg::idx_t in_user, in_fw, in_lf, in_rf;
  logic           in_xfer;
  logic           in_act;

  cmfa_pkg::idx_t      fork_sel;
  cmfa_pkg::step_ctl_t ctl;
  cmfa_pkg::fork_ent_t ent;
  cmfa_pkg::fork_upd_t upd;
  logic                holder_eating;
  logic                step_wr;

  logic                out_free;
  logic                out_load;
  logic                granted_fin;
  logic [1:0]          moved_fin;

  assign in_op   = in_tdata[1:0];
  assign in_user = in_tdata[5:2];
  assign in_fw   = in_tdata[9:6];
  assign in_lf   = in_tdata[13:10];
  assign in_rf   = in_tdata[17:14];

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // result register is free when empty or being taken this cycle
  assign out_free = !out_valid_r || out_tready;
  assign out_load = ((state_r == ST_B) || (state_r == ST_WAIT)) && out_free;

  always_comb begin
    in_act = 1'b0;
    if (cmfa_pkg::idx_ok(in_user)) begin
      unique case (in_op) inside
        cmfa_pkg::OP_REQ: in_act = cmfa_pkg::idx_ok(in_fw);
        cmfa_pkg::OP_EAT,
        cmfa_pkg::OP_REL: in_act = cmfa_pkg::idx_ok(in_lf) && cmfa_pkg::idx_ok(in_rf);
        default:          in_act = 1'b0;
      endcase
    end
  end

  assign fork_sel = (state_r == ST_B) ? fork_b_r : fork_a_r;

  always_comb begin
    ent.owner     = fork_owner_r[fork_sel];
    ent.dirty     = fork_dirty_r[fork_sel];
    ent.pending   = request_pending_r[fork_sel];
    ent.requester = fork_requester_r[fork_sel];
  end

  assign holder_eating = user_eating_r[ent.owner];

  // requests only touch their fork in the first step; a release on one
  // fork twice has nothing left to do in the second step
  assign ctl.en   = act_r && ((state_r == ST_A) ||
                    ((state_r == ST_B) && (op_r == cmfa_pkg::OP_REL) &&
                     (fork_b_r != fork_a_r)));
  assign ctl.op   = op_r;
  assign ctl.user = user_r;
  assign step_wr  = ctl.en;

  assign granted_fin = ((state_r == ST_B) && act_r && (op_r == cmfa_pkg::OP_EAT)) ?
                       (own_a_r && upd.own) : granted_r;
  assign moved_fin   = moved_r + {1'b0, step_wr && upd.move};

  cmfa_fork_unit u_fork_unit (
    .ctl          (ctl),
    .ent          (ent),
    .holder_eating(holder_eating),
    .upd          (upd)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_A;
      ST_A:    state_nxt = ST_B;
      ST_B:    state_nxt = out_free ? ST_IDLE : ST_WAIT;
      ST_WAIT: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int k = 0; k < cmfa_pkg::NUM_USERS; k++) begin
        fork_owner_r[k]     <= cmfa_pkg::IDX_W'(k);
        fork_requester_r[k] <= '0;
      end
      fork_dirty_r      <= '1;
      request_pending_r <= '0;
      user_eating_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (in_xfer && in_act && (in_op == cmfa_pkg::OP_REL)) begin
        user_eating_r[in_user] <= 1'b0;
      end
      if (state_r == ST_B && act_r && op_r == cmfa_pkg::OP_EAT && own_a_r && upd.own) begin
        user_eating_r[user_r] <= 1'b1;
      end
      if (step_wr) begin
        fork_owner_r[fork_sel]      <= upd.ent.owner;
        fork_dirty_r[fork_sel]      <= upd.ent.dirty;
        request_pending_r[fork_sel] <= upd.ent.pending;
        fork_requester_r[fork_sel]  <= upd.ent.requester;
      end
    end
  end

  // event payload and result accumulation
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {5'd0, moved_fin, granted_fin};
    end
    if (in_xfer) begin
      op_r      <= in_op;
      user_r    <= in_user;
      fork_a_r  <= (in_op == cmfa_pkg::OP_REQ) ? in_fw : in_lf;
      fork_b_r  <= in_rf;
      act_r     <= in_act;
      own_a_r   <= 1'b0;
      granted_r <= 1'b0;
      moved_r   <= 2'd0;
    end else begin
      if (state_r == ST_A) begin
        own_a_r <= upd.own;
        if (act_r && op_r == cmfa_pkg::OP_REQ) begin
          granted_r <= upd.own || upd.move;
        end
      end
      if (state_r == ST_B && act_r && op_r == cmfa_pkg::OP_EAT) begin
        granted_r <= own_a_r && upd.own;
      end
      if (step_wr && upd.move) begin
        moved_r <= moved_r + 2'd1;
      end
    end
  end

`include "chandy_misra_fork_arbiter_macros.svh"

  `CMFA_ASSERT(a_moved_max, out_valid_r |-> (out_data_r[2:1] != 2'd3))
  `CMFA_ASSERT_NEXT(a_rel_no_grant, (state_r == ST_B) && (op_r == cmfa_pkg::OP_REL), !granted_r)
  `CMFA_ASSERT_NEXT(a_move_clean, step_wr && upd.move, !fork_dirty_r[$past(fork_sel)])
  `CMFA_ASSERT_NEXT(a_step_b_out, state_r == ST_B, out_valid_r && (state_r != ST_A) && (state_r != ST_B))

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import cmfa_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int EVENTS_PER_PHASE = 500;
  localparam int NUM_PHASES = 4;
  localparam int NUM_ROWS = 23;

  typedef struct packed {
    logic       granted;
    logic [1:0] moved;
  } verdict_t;

  typedef struct packed {
    logic [1:0] op;
    idx_t       user;
    idx_t       fw;
    idx_t       lf;
    idx_t       rf;
    logic       known;
    logic       granted;
    logic [1:0] moved;
  } stim_row_t;

  // ownership walk-through from reset; known rows carry their expected result
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{OP_REQ,    4'd0,  4'd0,  4'd0,  4'd0,  1'b1, 1'b1, 2'd0},
    '{OP_REQ,    4'd1,  4'd0,  4'd1,  4'd2,  1'b1, 1'b1, 2'd1},
    '{OP_REQ,    4'd0,  4'd0,  4'd0,  4'd1,  1'b1, 1'b0, 2'd0},
    '{OP_EAT,    4'd1,  4'd9,  4'd0,  4'd1,  1'b0, 1'b0, 2'd0},
    '{OP_REQ,    4'd2,  4'd1,  4'd2,  4'd3,  1'b0, 1'b0, 2'd0},
    '{OP_REL,    4'd1,  4'd7,  4'd0,  4'd1,  1'b0, 1'b0, 2'd0},
    '{OP_UNUSED, 4'd15, 4'd15, 4'd15, 4'd15, 1'b1, 1'b0, 2'd0},
    '{OP_EAT,    4'd15, 4'd0,  4'd15, 4'd15, 1'b1, 1'b1, 2'd0},
    '{OP_REL,    4'd15, 4'd15, 4'd15, 4'd15, 1'b1, 1'b0, 2'd0},
    '{OP_REQ,    4'd14, 4'd15, 4'd14, 4'd15, 1'b0, 1'b0, 2'd0},
    '{OP_EAT,    4'd14, 4'd3,  4'd15, 4'd15, 1'b0, 1'b0, 2'd0},
    '{OP_REQ,    4'd13, 4'd15, 4'd13, 4'd14, 1'b0, 1'b0, 2'd0},
    // same fork on both sides while a request waits
    '{OP_REL,    4'd14, 4'd0,  4'd15, 4'd15, 1'b0, 1'b0, 2'd0},
    '{OP_EAT,    4'd13, 4'd15, 4'd15, 4'd15, 1'b0, 1'b0, 2'd0},
    // second request overwrites the first
    '{OP_REQ,    4'd12, 4'd15, 4'd12, 4'd13, 1'b0, 1'b0, 2'd0},
    '{OP_REQ,    4'd11, 4'd15, 4'd11, 4'd12, 1'b0, 1'b0, 2'd0},
    '{OP_REL,    4'd13, 4'd5,  4'd15, 4'd15, 1'b0, 1'b0, 2'd0},
    '{OP_REQ,    4'd11, 4'd15, 4'd0,  4'd0,  1'b0, 1'b0, 2'd0},
    '{OP_REQ,    4'd12, 4'd15, 4'd15, 4'd15, 1'b0, 1'b0, 2'd0},
    '{OP_EAT,    4'd15, 4'd15, 4'd14, 4'd0,  1'b0, 1'b0, 2'd0},
    '{OP_UNUSED, 4'd0,  4'd0,  4'd0,  4'd0,  1'b1, 1'b0, 2'd0},
    '{OP_REL,    4'd11, 4'd15, 4'd15, 4'd15, 1'b0, 1'b0, 2'd0},
    '{OP_REQ,    4'd15, 4'd11, 4'd15, 4'd0,  1'b0, 1'b0, 2'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int errors = 0;

  // predicted arbiter state
  idx_t fork_holder [NUM_USERS];
  logic fork_soiled [NUM_USERS];
  logic fork_asked  [NUM_USERS];
  idx_t fork_asker  [NUM_USERS];
  logic user_dining [NUM_USERS];

  verdict_t expected_results [$];

  chandy_misra_fork_arbiter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  function automatic logic hand_over(input idx_t f);
    if (!fork_asked[f] || fork_asker[f] == fork_holder[f]) return 1'b0;
    if (fork_soiled[f] && !user_dining[fork_holder[f]]) begin
      fork_holder[f] = fork_asker[f];
      fork_soiled[f] = 1'b0;
      fork_asked[f]  = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic verdict_t arbitrate(input logic [1:0] op, input idx_t u,
                                         input idx_t fw, input idx_t lf, input idx_t rf);
    verdict_t v;
    logic     a;
    logic     b;
    v = '0;
    if (int'(u) >= NUM_USERS) return v;
    case (op)
      OP_REQ: begin
        if (int'(fw) < NUM_USERS) begin
          if (fork_holder[fw] == u) begin
            v.granted = 1'b1;
          end else begin
            fork_asked[fw] = 1'b1;
            fork_asker[fw] = u;
            v.moved   = {1'b0, hand_over(fw)};
            v.granted = (fork_holder[fw] == u);
          end
        end
      end
      OP_EAT: begin
        if (int'(lf) < NUM_USERS && int'(rf) < NUM_USERS &&
            fork_holder[lf] == u && fork_holder[rf] == u) begin
          user_dining[u] = 1'b1;
          v.granted = 1'b1;
        end
      end
      OP_REL: begin
        if (int'(lf) < NUM_USERS && int'(rf) < NUM_USERS) begin
          user_dining[u] = 1'b0;
          if (fork_holder[lf] == u) fork_soiled[lf] = 1'b1;
          if (fork_holder[rf] == u) fork_soiled[rf] = 1'b1;
          a = hand_over(lf);
          b = hand_over(rf);
          v.moved = {1'b0, a} + {1'b0, b};
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  // entered and left at a falling edge
  task automatic send_event(input logic [1:0] op, input idx_t u, input idx_t fw,
                            input idx_t lf, input idx_t rf, input logic known,
                            input verdict_t typed);
    verdict_t v;
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {6'b0, rf, lf, fw, u, op};
    do @(posedge clk); while (!in_tready);
    v = arbitrate(op, u, fw, lf, rf);
    expected_results.push_back(known ? typed : v);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_tvalid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected, got granted=%0b moved=%0d",
                 $time, out_tdata[0], out_tdata[2:1]);
        errors++;
      end else begin
        exp_v = expected_results.pop_front();
        if (out_tdata[0] !== exp_v.granted) begin
          $display("%0t: granted expected %0b got %0b", $time, exp_v.granted, out_tdata[0]);
          errors++;
        end
        if (out_tdata[2:1] !== exp_v.moved) begin
          $display("%0t: forks_moved expected %0d got %0d", $time, exp_v.moved,
                   out_tdata[2:1]);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("chandy_misra_fork_arbiter regression: fail");
    $finish;
  end

  initial begin
    logic [1:0] stage [NUM_USERS];
    logic [1:0] op;
    idx_t       u;
    idx_t       fw;
    idx_t       lf;
    idx_t       rf;
    idx_t       tmp;
    for (int k = 0; k < NUM_USERS; k++) begin
      fork_holder[k] = idx_t'(k);
      fork_soiled[k] = 1'b1;
      fork_asked[k]  = 1'b0;
      fork_asker[k]  = '0;
      user_dining[k] = 1'b0;
      stage[k]       = 2'd0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      send_event(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].user, DIRECTED_ROWS[i].fw,
                 DIRECTED_ROWS[i].lf, DIRECTED_ROWS[i].rf, DIRECTED_ROWS[i].known,
                 '{DIRECTED_ROWS[i].granted, DIRECTED_ROWS[i].moved});
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      // hold off until the arbiter has drained before changing the pacing
      wait_for_results();
      case (p)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 82; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 82; end
        default: begin src_idle_pct = 32; snk_stall_pct = 32; end
      endcase
      for (int n = 0; n < EVENTS_PER_PHASE; n++) begin
        if ($urandom_range(99) < 85) begin
          // one philosopher on the ring takes its next step
          u  = idx_t'($urandom_range(NUM_USERS - 1));
          lf = u;
          rf = u + 1'b1;
          if ($urandom_range(9) == 0) begin
            tmp = lf;
            lf  = rf;
            rf  = tmp;
          end
          fw = idx_t'($urandom_range(15));
          case (stage[u])
            2'd0: begin op = OP_REQ; fw = lf; end
            2'd1: begin op = OP_REQ; fw = rf; end
            2'd2: op = OP_EAT;
            default: op = OP_REL;
          endcase
          stage[u] = stage[u] + 1'b1;
        end else begin
          op = 2'($urandom_range(3));
          u  = idx_t'($urandom_range(15));
          fw = idx_t'($urandom_range(15));
          lf = idx_t'($urandom_range(15));
          rf = idx_t'($urandom_range(15));
        end
        send_event(op, u, fw, lf, rf, 1'b0, '0);
      end
    end

    in_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("chandy_misra_fork_arbiter regression: pass");
    end else begin
      $display("chandy_misra_fork_arbiter regression: fail");
    end
    $finish;
  end

endmodule
